>>> rtl/core/pdr_pkg.sv
// Package for the Pareto dominance rank block: field widths and the
// compare-stage tag shared by the controller and the rank unit. No dependencies.
package pdr_pkg;

    localparam int VALUE_W   = 32;
    localparam int DIM_W     = 4;
    localparam int VEC_IDX_W = 5;
    localparam int RANK_W    = 5;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

    typedef logic signed [VALUE_W-1:0] t_value;

    // tag that travels with each pair of store reads
    typedef struct packed {
        logic                 valid;
        logic                 first_k;
        logic                 last_k;
        logic                 first_j;
        logic                 last_j;
        logic                 last_i;
        logic                 same;
        logic                 ovf;
        logic [VEC_IDX_W-1:0] vec_index;
    } t_tag;

endpackage

>>> rtl/core/pdr_if.sv
// Channel interfaces for the Pareto dominance rank block: component input,
// result output and dim_count write. Depends on pdr_pkg.
interface pdr_in_if;
    logic             valid;
    logic             ready;
    pdr_pkg::t_value  value;
    logic             last;
    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface pdr_out_if;
    logic                          valid;
    logic                          ready;
    logic [pdr_pkg::VEC_IDX_W-1:0] vector_index;
    logic [pdr_pkg::RANK_W-1:0]    rank;
    logic                          overflow;
    logic                          end_of_run;
    modport source (output valid, output vector_index, output rank, output overflow,
                    output end_of_run, input ready);
    modport sink   (input valid, input vector_index, input rank, input overflow,
                    input end_of_run, output ready);
endinterface

interface pdr_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [pdr_pkg::DIM_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/pdr_store.sv
// Component store: one write port, two registered read ports with a shared
// read enable. Depends on pdr_pkg.
module pdr_store #(
    parameter int AW    = 8,
    parameter int DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pdr_pkg::t_value i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr_a,
    input  logic [AW-1:0]   i_raddr_b,
    output pdr_pkg::t_value o_rdata_a,
    output pdr_pkg::t_value o_rdata_b
);

    pdr_pkg::t_value mem [DEPTH];
    pdr_pkg::t_value r_rdata_a;
    pdr_pkg::t_value r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/core/pdr_ctrl.sv
// Controller: dim_count register, component loading into the store, and the
// pair sequencer that walks (i, j, k) during ranking. Depends on pdr_pkg, pdr_if.
module pdr_ctrl #(
    parameter int MAX_VECTORS = 32,
    parameter int MAX_DIMS    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pdr_in_if.sink        i_in,
    pdr_cfg_if.sink       i_cfg,
    input  logic          i_adv,
    output logic          o_we,
    output logic [$clog2(MAX_VECTORS)+((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] o_waddr,
    output pdr_pkg::t_value o_wdata,
    output logic [$clog2(MAX_VECTORS)+((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] o_raddr_a,
    output logic [$clog2(MAX_VECTORS)+((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] o_raddr_b,
    output pdr_pkg::t_tag o_tag
);

    localparam int RW  = $clog2(MAX_VECTORS);
    localparam int CW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PIW = CW + 1;
    localparam int VCW = $clog2(MAX_VECTORS + 1);
    localparam int DW  = $clog2(MAX_DIMS + 1);

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_RANK = 2'b10
    } t_state;

    t_state                      r_state;
    logic [pdr_pkg::DIM_W-1:0]   r_dim;
    logic [CW-1:0]               r_pos;
    logic [VCW-1:0]              r_vc;
    logic                        r_drop;
    logic [VCW-1:0]              r_n;
    logic                        r_ovf;
    logic [RW-1:0]               r_i;
    logic [RW-1:0]               r_j;
    logic [CW-1:0]               r_k;

    logic [DW-1:0]  act;
    logic           accept;
    logic           room;
    logic [PIW-1:0] pos_inc;
    logic           complete;
    logic [CW-1:0]  n_pos;
    logic [VCW-1:0] n_vc;
    logic           n_drop;
    logic           k_last;
    logic           j_last;
    logic           i_last;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_LOAD);
    assign accept      = i_in.valid && i_in.ready;

    always_comb begin
        if (r_dim == '0) begin
            act = DW'(1);
        end else if (32'(r_dim) > MAX_DIMS) begin
            act = DW'(MAX_DIMS);
        end else begin
            act = DW'(r_dim);
        end
    end

    assign room     = 32'(r_vc) < MAX_VECTORS;
    assign pos_inc  = PIW'(r_pos) + PIW'(1);
    assign complete = 32'(pos_inc) >= 32'(act);
    assign n_pos    = complete ? '0 : pos_inc[CW-1:0];
    assign n_vc     = (complete && room) ? r_vc + VCW'(1) : r_vc;
    assign n_drop   = r_drop | (complete && !room);

    assign o_we      = accept && room;
    assign o_waddr   = {r_vc[RW-1:0], r_pos};
    assign o_wdata   = i_in.value;
    assign o_raddr_a = {r_j, r_k};
    assign o_raddr_b = {r_i, r_k};

    assign k_last = (32'(r_k) + 1) == 32'(act);
    assign j_last = (32'(r_j) + 1) == 32'(r_n);
    assign i_last = (32'(r_i) + 1) == 32'(r_n);

    always_comb begin
        o_tag.valid     = (r_state == S_RANK);
        o_tag.first_k   = (r_k == '0);
        o_tag.last_k    = k_last;
        o_tag.first_j   = (r_j == '0);
        o_tag.last_j    = j_last;
        o_tag.last_i    = i_last;
        o_tag.same      = (r_i == r_j);
        o_tag.ovf       = r_ovf;
        o_tag.vec_index = pdr_pkg::VEC_IDX_W'(32'(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_dim   <= pdr_pkg::DIM_RESET;
            r_pos   <= '0;
            r_vc    <= '0;
            r_drop  <= 1'b0;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_dim <= i_cfg.data;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (i_in.last) begin
                            r_pos  <= '0;
                            r_vc   <= '0;
                            r_drop <= 1'b0;
                            r_n    <= n_vc;
                            r_ovf  <= n_drop;
                            r_i    <= '0;
                            r_j    <= '0;
                            r_k    <= '0;
                            if (n_vc != '0) begin
                                r_state <= S_RANK;
                            end
                        end else begin
                            r_pos  <= n_pos;
                            r_vc   <= n_vc;
                            r_drop <= n_drop;
                        end
                    end
                end
                S_RANK: begin
                    if (i_adv) begin
                        if (k_last) begin
                            r_k <= '0;
                            if (j_last) begin
                                r_j <= '0;
                                if (i_last) begin
                                    r_state <= S_LOAD;
                                end else begin
                                    r_i <= r_i + RW'(1);
                                end
                            end else begin
                                r_j <= r_j + RW'(1);
                            end
                        end else begin
                            r_k <= r_k + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/pdr_rank.sv
// Rank unit: compares the two read words, accumulates dominance per pair and
// the count per vector, and holds the result word. Depends on pdr_pkg, pdr_if.
module pdr_rank #(
    parameter int MAX_VECTORS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pdr_pkg::t_tag   i_tag,
    input  pdr_pkg::t_value i_rd_a,
    input  pdr_pkg::t_value i_rd_b,
    output logic            o_adv,
    pdr_out_if.source       o_res
);

    localparam int RKW = $clog2(MAX_VECTORS);

    pdr_pkg::t_tag                 r_tag;
    logic                          r_le;
    logic                          r_lt;
    logic [RKW-1:0]                r_rank;
    logic                          r_out_valid;
    logic [pdr_pkg::VEC_IDX_W-1:0] r_out_index;
    logic [pdr_pkg::RANK_W-1:0]    r_out_rank;
    logic                          r_out_ovf;
    logic                          r_out_end;

    logic           le_now;
    logic           lt_now;
    logic           dom;
    logic [RKW-1:0] rank_now;
    logic           final_pair;

    assign o_adv = !r_out_valid || o_res.ready;

    // j dominates i: a (vector j) never above b (vector i), strictly below once
    assign le_now     = (r_tag.first_k || r_le) && !(i_rd_b < i_rd_a);
    assign lt_now     = (!r_tag.first_k && r_lt) || (i_rd_a < i_rd_b);
    assign dom        = le_now && lt_now && !r_tag.same;
    assign rank_now   = (r_tag.first_j ? '0 : r_rank) + RKW'(dom);
    assign final_pair = r_tag.valid && r_tag.last_k && r_tag.last_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag       <= '0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_tag       <= i_tag;
            r_out_valid <= final_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && r_tag.valid) begin
            r_le <= le_now;
            r_lt <= lt_now;
            if (r_tag.last_k) begin
                r_rank <= rank_now;
            end
        end
        if (o_adv && final_pair) begin
            r_out_index <= r_tag.vec_index;
            r_out_rank  <= pdr_pkg::RANK_W'(32'(rank_now));
            r_out_ovf   <= r_tag.ovf;
            r_out_end   <= r_tag.last_i;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.vector_index = r_out_index;
    assign o_res.rank         = r_out_rank;
    assign o_res.overflow     = r_out_ovf;
    assign o_res.end_of_run   = r_out_end;

endmodule

>>> rtl/core/pareto_dominance_rank.sv
// Top level of the Pareto dominance rank block: controller, component store
// and rank unit. Depends on pdr_pkg, pdr_if, pdr_store, pdr_ctrl, pdr_rank.
//
//   channel  dir  word                                      when taken
//   i_in     in   value (s32), last                         valid & ready
//   i_cfg    in   data = dim_count (u4)                     valid & ready
//   o_res    out  vector_index, rank, overflow, end_of_run  valid & ready
//
// Loading takes one component per cycle. After the word marked last, ranking
// reads one pair of the store per cycle while the result word is not stalled,
// and results follow in load order, n per set (n stored vectors).
// Input is not taken while ranking; dim_count writes are taken at any time.
// A stalled result word freezes the compare pipeline. Reset is synchronous,
// active low; the store itself is not cleared.
module pareto_dominance_rank #(
    parameter int MAX_VECTORS = 32,
    parameter int MAX_DIMS    = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdr_in_if.sink    i_in,
    pdr_cfg_if.sink   i_cfg,
    pdr_out_if.source o_res
);

    localparam int RW    = $clog2(MAX_VECTORS);
    localparam int CW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_VECTORS * (1 << CW);

    logic            adv;
    logic            we;
    logic [AW-1:0]   waddr;
    pdr_pkg::t_value wdata;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    pdr_pkg::t_value rdata_a;
    pdr_pkg::t_value rdata_b;
    pdr_pkg::t_tag   tag;

    pdr_ctrl #(
        .MAX_VECTORS (MAX_VECTORS),
        .MAX_DIMS    (MAX_DIMS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_adv     (adv),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .o_tag     (tag)
    );

    pdr_store #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (adv),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    pdr_rank #(
        .MAX_VECTORS (MAX_VECTORS)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tag),
        .i_rd_a  (rdata_a),
        .i_rd_b  (rdata_b),
        .o_adv   (adv),
        .o_res   (o_res)
    );

    // no store write while the sequencer is reading pairs
    a_no_load_in_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && tag.valid))
        else $error("input ready while ranking");

    a_no_write_in_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && tag.valid))
        else $error("store write during ranking");

    // a stalled result holds the sequencer on its current pair
    a_stall_holds_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && tag.valid) |=> $stable(tag) && $stable(raddr_a) && $stable(raddr_b))
        else $error("sequencer moved during stall");

endmodule
